// File: sv/rrp_pkg.sv
// ----------------------------------------------------------------------------
// rrp_pkg
// Shared types and constants of the roulette region placer.
// ----------------------------------------------------------------------------
`default_nettype none

package rrp_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_PLACE  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        STS_OK     = 3'd0,
        STS_FULL   = 3'd1,
        STS_ORDER  = 3'd2,
        STS_EMPTY  = 3'd3,
        STS_REJECT = 3'd4
    } status_t;

    localparam int COORD_W  = 32;
    localparam int IDX_OUT_W = 8;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int M_DATA_W = 72;

endpackage

`default_nettype wire

// File: sv/rrp_ram.sv
// ----------------------------------------------------------------------------
// rrp_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module rrp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: sv/roulette_region_placer_top.sv
// ----------------------------------------------------------------------------
// roulette_region_placer_top
// One transaction in flight. Clear, append and empty-table place go from
// accept to the response state; place runs multiply low, multiply high, add,
// binary search (one interval RAM read per probe), check, offset and finish,
// a reject ending at check. Next accept the cycle after the result registers.
// Synchronous active-low reset empties the table; RAM contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module roulette_region_placer_top #(
    parameter int MAX_FREE  = 256,
    parameter int RAND_BITS = 24
) (
    input  wire logic aclk,
    input  wire logic aresetn,

    input  wire logic                                          s_axis_tvalid,
    output logic                                               s_axis_tready,
    // region_first, region_last, place_length, rnd_select, rnd_offset
    input  wire logic [((3*rrp_pkg::COORD_W+2*RAND_BITS+7)/8)*8-1:0] s_axis_tdata,
    // op
    input  wire logic [rrp_pkg::OP_W-1:0]                      s_axis_tuser,

    output logic                                               m_axis_tvalid,
    input  wire logic                                          m_axis_tready,
    // chosen_index, placed_first, placed_last
    output logic [rrp_pkg::M_DATA_W-1:0]                       m_axis_tdata,
    // status
    output logic [rrp_pkg::STATUS_W-1:0]                       m_axis_tuser
);

    localparam int CW   = rrp_pkg::COORD_W;
    localparam int IW   = $clog2(MAX_FREE);
    localparam int NW   = $clog2(MAX_FREE + 1);
    localparam int SW   = CW + 1 + IW;
    localparam int XW   = SW + RAND_BITS;
    localparam int PW   = CW + RAND_BITS;
    localparam int RW   = 2 * CW + SW;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_LO,
        S_MUL_HI,
        S_ADD,
        S_SRCH,
        S_CHECK,
        S_OFFS,
        S_FIN,
        S_RESP
    } state_t;

    state_t state_reg;

    logic [NW-1:0]        cnt_reg;
    logic [SW-1:0]        total_reg;
    logic [CW-1:0]        len_reg;
    logic [RAND_BITS-1:0] rsel_reg;
    logic [RAND_BITS-1:0] roff_reg;
    logic [IW-1:0]        lo_reg;
    logic [IW-1:0]        hi_reg;
    logic [IW-1:0]        mid_reg;
    logic [PW-1:0]        prod_reg;
    logic [PW-1:0]        plo_reg;
    logic [XW-1:0]        x_reg;
    logic [CW-1:0]        s_reg;
    logic [CW-1:0]        span_reg;

    rrp_pkg::status_t       res_status_reg;
    logic [IW-1:0]          res_idx_reg;
    logic [CW-1:0]          res_first_reg;
    logic [CW-1:0]          res_last_reg;

    logic                            m_valid_reg;
    rrp_pkg::status_t                m_status_reg;
    logic [rrp_pkg::IDX_OUT_W-1:0]   m_idx_reg;
    logic [CW-1:0]                   m_first_reg;
    logic [CW-1:0]                   m_last_reg;

    // input fields
    rrp_pkg::op_t         in_op;
    logic [CW-1:0]        in_first;
    logic [CW-1:0]        in_last;
    logic [CW-1:0]        in_len;
    logic [RAND_BITS-1:0] in_rsel;
    logic [RAND_BITS-1:0] in_roff;

    assign in_op    = rrp_pkg::op_t'(s_axis_tuser);
    assign in_first = s_axis_tdata[CW-1:0];
    assign in_last  = s_axis_tdata[2*CW-1:CW];
    assign in_len   = s_axis_tdata[3*CW-1:2*CW];
    assign in_rsel  = s_axis_tdata[3*CW +: RAND_BITS];
    assign in_roff  = s_axis_tdata[3*CW+RAND_BITS +: RAND_BITS];

    logic accept;
    logic out_free;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    // interval RAM: {running sum, last, first}
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [RW-1:0] ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [RW-1:0] ram_rdata;

    rrp_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_FREE)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [CW-1:0] rd_first;
    logic [CW-1:0] rd_last;
    logic [SW-1:0] rd_sum;
    assign rd_first = ram_rdata[CW-1:0];
    assign rd_last  = ram_rdata[2*CW-1:CW];
    assign rd_sum   = ram_rdata[2*CW +: SW];

    // append
    logic          app_full;
    logic          app_order;
    logic [CW:0]   app_len;
    logic [SW-1:0] app_total;

    assign app_full  = (cnt_reg == NW'(MAX_FREE));
    assign app_order = (in_last < in_first);
    assign app_len   = {1'b0, in_last} - {1'b0, in_first} + {{CW{1'b0}}, 1'b1};
    assign app_total = total_reg + SW'(app_len);

    assign ram_we    = accept && (in_op == rrp_pkg::OP_APPEND) && !app_full && !app_order;
    assign ram_waddr = cnt_reg[IW-1:0];
    assign ram_wdata = {app_total, in_last, in_first};

    // shared multiplier
    logic [CW-1:0]        mul_a;
    logic [RAND_BITS-1:0] mul_b;
    logic [PW-1:0]        mul_p;

    always_comb begin
        case (state_reg)
            S_MUL_LO: begin
                mul_a = total_reg[CW-1:0];
                mul_b = rsel_reg;
            end
            S_MUL_HI: begin
                mul_a = CW'(total_reg[SW-1:CW]);
                mul_b = rsel_reg;
            end
            default: begin
                mul_a = span_reg;
                mul_b = roff_reg;
            end
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // binary search step
    logic          reach;
    logic [IW-1:0] cur_mid;
    logic [IW-1:0] lo_next;
    logic [IW-1:0] hi_next;
    logic [IW-1:0] mid_next;

    assign reach    = ({rd_sum, {RAND_BITS{1'b0}}} >= x_reg);
    assign cur_mid  = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign lo_next  = reach ? lo_reg : (mid_reg + {{(IW-1){1'b0}}, 1'b1});
    assign hi_next  = reach ? mid_reg : hi_reg;
    assign mid_next = lo_next + ((hi_next - lo_next) >> 1);

    always_comb begin
        case (state_reg)
            S_SRCH:  ram_raddr = mid_next;
            default: ram_raddr = cur_mid;
        endcase
    end

    // interval check
    logic [CW:0]   chk_len;
    logic [CW+2:0] chk_span;
    assign chk_len  = {1'b0, rd_last} - {1'b0, rd_first} + {{CW{1'b0}}, 1'b1};
    assign chk_span = {3'b000, rd_last} - {3'b000, len_reg} - {3'b000, rd_first};

    logic [CW-1:0] fin_start;
    assign fin_start = s_reg + prod_reg[PW-1:RAND_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_axis_tready && (state_reg != S_RESP)) begin
                m_valid_reg <= 1'b0;
            end
            prod_reg <= mul_p;
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        len_reg        <= in_len;
                        rsel_reg       <= in_rsel;
                        roff_reg       <= in_roff;
                        res_status_reg <= rrp_pkg::STS_OK;
                        res_idx_reg    <= '0;
                        res_first_reg  <= '0;
                        res_last_reg   <= '0;
                        lo_reg         <= '0;
                        hi_reg         <= IW'(cnt_reg - {{(NW-1){1'b0}}, 1'b1});
                        state_reg      <= S_RESP;
                        case (in_op)
                            rrp_pkg::OP_CLEAR: begin
                                cnt_reg   <= '0;
                                total_reg <= '0;
                            end
                            rrp_pkg::OP_APPEND: begin
                                res_idx_reg <= IW'(cnt_reg);
                                if (app_full) begin
                                    res_status_reg <= rrp_pkg::STS_FULL;
                                end else if (app_order) begin
                                    res_status_reg <= rrp_pkg::STS_ORDER;
                                end else begin
                                    total_reg <= app_total;
                                    cnt_reg   <= cnt_reg + {{(NW-1){1'b0}}, 1'b1};
                                end
                            end
                            rrp_pkg::OP_PLACE: begin
                                if (cnt_reg == '0) begin
                                    res_status_reg <= rrp_pkg::STS_EMPTY;
                                end else begin
                                    state_reg <= S_MUL_LO;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_MUL_LO: begin
                    state_reg <= S_MUL_HI;
                end
                S_MUL_HI: begin
                    plo_reg   <= prod_reg;
                    state_reg <= S_ADD;
                end
                S_ADD: begin
                    x_reg     <= XW'(plo_reg) + (XW'(prod_reg) << CW);
                    mid_reg   <= cur_mid;
                    state_reg <= (lo_reg == hi_reg) ? S_CHECK : S_SRCH;
                end
                S_SRCH: begin
                    lo_reg    <= lo_next;
                    hi_reg    <= hi_next;
                    mid_reg   <= mid_next;
                    state_reg <= (lo_next == hi_next) ? S_CHECK : S_SRCH;
                end
                S_CHECK: begin
                    res_idx_reg <= lo_reg;
                    s_reg       <= rd_first;
                    span_reg    <= chk_span[CW+2] ? '0 : chk_span[CW-1:0];
                    if (chk_len < {1'b0, len_reg}) begin
                        res_status_reg <= rrp_pkg::STS_REJECT;
                        state_reg      <= S_RESP;
                    end else begin
                        state_reg <= S_OFFS;
                    end
                end
                S_OFFS: begin
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    res_first_reg <= fin_start;
                    res_last_reg  <= fin_start + len_reg - {{(CW-1){1'b0}}, 1'b1};
                    state_reg     <= S_RESP;
                end
                S_RESP: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_idx_reg    <= rrp_pkg::IDX_OUT_W'(res_idx_reg);
                        m_first_reg  <= res_first_reg;
                        m_last_reg   <= res_last_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = {m_last_reg, m_first_reg, m_idx_reg};

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= NW'(MAX_FREE))
        else $error("entry count above table depth");

    a_search_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SRCH) |-> (lo_reg < hi_reg) && (NW'(hi_reg) < cnt_reg))
        else $error("search bounds out of range");

    a_resp_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESP && out_free) |=> m_axis_tvalid && s_axis_tready)
        else $error("result not registered after response");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second transaction accepted while busy");
`endif

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the roulette region placer: clear, append and place
// commands go in on the input channel; a predictor with its own copy of the
// interval table works out each result, and a checker compares every output
// transaction field by field. Both sides insert random idle bursts.
// ----------------------------------------------------------------------------

module tb_top;

    localparam int RAND_W      = 24;
    localparam int TABLE_DEPTH = 256;
    localparam int S_DATA_W    = ((3*rrp_pkg::COORD_W + 2*RAND_W + 7)/8)*8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_TARGET = 400;
    localparam logic [rrp_pkg::OP_W-1:0] OP_RESERVED = 2'd3;

    typedef struct packed {
        rrp_pkg::status_t sts;
        logic [7:0]       index;
        logic [31:0]      first;
        logic [31:0]      last;
    } outcome_t;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_axis_tready;
    logic [S_DATA_W-1:0]          s_data = '0;
    logic [rrp_pkg::OP_W-1:0]     s_user = '0;
    logic                         m_axis_tvalid;
    logic                         m_ready = 1'b0;
    logic [rrp_pkg::M_DATA_W-1:0] m_axis_tdata;
    logic [rrp_pkg::STATUS_W-1:0] m_axis_tuser;

    // predictor copy of the interval table
    logic [31:0] tbl_first [TABLE_DEPTH];
    logic [31:0] tbl_last  [TABLE_DEPTH];
    logic [40:0] tbl_cum   [TABLE_DEPTH];
    int unsigned tbl_count = 0;
    logic [40:0] tbl_total = '0;

    outcome_t outcome_q[$];
    outcome_t due;
    int       error_count = 0;
    int       items_sent = 0;
    int       cycle_count = 0;
    bit       tx_gaps_on = 1'b1;
    bit       rx_gaps_on = 1'b1;
    int       rx_hold_cycles = 0;

    roulette_region_placer_top #(
        .MAX_FREE  (TABLE_DEPTH),
        .RAND_BITS (RAND_W)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),     // region_first, region_last, place_length, rnd_select, rnd_offset
        .s_axis_tuser  (s_user),     // op
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata), // chosen_index, placed_first, placed_last
        .m_axis_tuser  (m_axis_tuser)  // status
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function automatic logic [23:0] rand_frac();
        logic [31:0] w;
        w = $urandom;
        return w[23:0];
    endfunction

    function automatic logic [31:0] rand_word();
        return $urandom;
    endfunction

    function automatic outcome_t predict_table_op(
        input logic [rrp_pkg::OP_W-1:0] op,
        input logic [31:0] first, last, len,
        input logic [23:0] rsel, roff
    );
        outcome_t    o;
        logic [65:0] target, opa, opb, reach;
        logic [32:0] ilen;
        logic [63:0] prod;
        logic [31:0] s, e, start;
        longint      se, sl, ss, span;
        int          k, idx;
        o = '{rrp_pkg::STS_OK, 8'd0, 32'd0, 32'd0};
        case (op)
            rrp_pkg::OP_CLEAR: begin
                tbl_count = 0;
                tbl_total = '0;
            end
            rrp_pkg::OP_APPEND: begin
                o.index = tbl_count[7:0];
                if (tbl_count >= TABLE_DEPTH) begin
                    o.sts = rrp_pkg::STS_FULL;
                end else if (last < first) begin
                    o.sts = rrp_pkg::STS_ORDER;
                end else begin
                    tbl_total = tbl_total + ({9'd0, last} - {9'd0, first} + 41'd1);
                    tbl_first[tbl_count] = first;
                    tbl_last[tbl_count] = last;
                    tbl_cum[tbl_count] = tbl_total;
                    tbl_count++;
                end
            end
            rrp_pkg::OP_PLACE: begin
                if (tbl_count == 0) begin
                    o.sts = rrp_pkg::STS_EMPTY;
                end else begin
                    opa = 66'(rsel);
                    opb = 66'(tbl_total);
                    target = opa * opb;
                    // smallest entry whose scaled running sum reaches the target
                    idx = tbl_count - 1;
                    for (k = tbl_count - 1; k >= 0; k--) begin
                        reach = 66'({tbl_cum[k], 24'd0});
                        if (reach >= target)
                            idx = k;
                    end
                    o.index = idx[7:0];
                    s = tbl_first[idx];
                    e = tbl_last[idx];
                    ilen = {1'b0, e} - {1'b0, s} + 33'd1;
                    if (ilen < {1'b0, len}) begin
                        o.sts = rrp_pkg::STS_REJECT;
                    end else begin
                        se = longint'(e);
                        sl = longint'(len);
                        ss = longint'(s);
                        span = se - sl - ss;
                        if (span < 0)
                            span = 0;
                        prod = 64'(span);
                        prod = prod * {40'd0, roff};
                        start = s + prod[55:24];
                        o.first = start;
                        o.last = start + len - 32'd1;
                    end
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want, got);
        $display("mismatch: %s, want %0h got %0h (cycle %0d)", what, want, got,
                 cycle_count);
        error_count++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_ready) begin
            if (outcome_q.size() == 0) begin
                report_mismatch("result with none pending", 32'd0, m_axis_tdata[31:0]);
            end else begin
                due = outcome_q.pop_front();
                if (m_axis_tuser !== due.sts)
                    report_mismatch("status", 32'(due.sts), 32'(m_axis_tuser));
                if (m_axis_tdata[7:0] !== due.index)
                    report_mismatch("chosen_index", 32'(due.index), 32'(m_axis_tdata[7:0]));
                if (m_axis_tdata[39:8] !== due.first)
                    report_mismatch("placed_first", due.first, m_axis_tdata[39:8]);
                if (m_axis_tdata[71:40] !== due.last)
                    report_mismatch("placed_last", due.last, m_axis_tdata[71:40]);
            end
        end
    end

    // result-side ready: random bursts, or a long hold on request
    initial begin
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (rx_hold_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge aclk);
                rx_hold_cycles = 0;
            end else if (rx_gaps_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    task automatic send_item(
        input logic [rrp_pkg::OP_W-1:0] op,
        input logic [31:0] first, last, len,
        input logic [23:0] rsel, roff,
        output rrp_pkg::status_t sts
    );
        outcome_t o;
        if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= {roff, rsel, len, last, first};
        s_user  <= op;
        do @(posedge aclk); while (!s_axis_tready);
        o = predict_table_op(op, first, last, len, rsel, roff);
        outcome_q.insert(outcome_q.size(), o);
        sts = o.sts;
        items_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic pick_interval(input bit broken, output logic [31:0] f, l);
        int mode;
        if (broken) begin
            f = $urandom_range(32'hFFFF_FFFF, 1);
            l = $urandom_range(f - 32'd1, 0);
        end else begin
            mode = $urandom_range(0, 19);
            if (mode < 8) begin
                f = $urandom_range(0, 4000);
                l = f + $urandom_range(0, 300);
            end else if (mode < 15) begin
                f = rand_word();
                l = $urandom_range(32'hFFFF_FFFF, f);
            end else if (mode < 17) begin
                f = 32'd0;
                l = 32'hFFFF_FFFF;
            end else begin
                l = 32'hFFFF_FFFF;
                f = l - $urandom_range(0, 1000);
            end
        end
    endtask

    // mostly lengths that fit some entry, with zero, oversize and raw words mixed in
    function automatic logic [31:0] pick_length();
        int          r, k;
        logic [32:0] ilen;
        logic [31:0] cap;
        r = $urandom_range(0, 9);
        if (tbl_count == 0 || r == 0)
            return rand_word();
        if (r == 1)
            return 32'd0;
        k = $urandom_range(0, tbl_count - 1);
        ilen = {1'b0, tbl_last[k]} - {1'b0, tbl_first[k]} + 33'd1;
        cap = ilen[32] ? 32'hFFFF_FFFF : ilen[31:0];
        if (r == 2 && cap != 32'hFFFF_FFFF)
            return cap + 32'd1;
        return $urandom_range(cap, 1);
    endfunction

    task automatic place_with_retry();
        rrp_pkg::status_t sts;
        logic [31:0] len;
        int tries;
        len = pick_length();
        tries = 0;
        do begin
            send_item(rrp_pkg::OP_PLACE, rand_word(), rand_word(), len, rand_frac(),
                      rand_frac(), sts);
            tries++;
        end while (sts == rrp_pkg::STS_REJECT && tries < 3);
    endtask

    task automatic append_random(input bit broken);
        rrp_pkg::status_t sts;
        logic [31:0] f, l;
        pick_interval(broken, f, l);
        send_item(rrp_pkg::OP_APPEND, f, l, rand_word(), rand_frac(), rand_frac(), sts);
    endtask

    task automatic test_directed_cases();
        rrp_pkg::status_t sts;
        send_item(rrp_pkg::OP_PLACE, 32'd0, 32'd0, 32'd1, 24'hFF_FFFF, 24'hFF_FFFF, sts);
        send_item(OP_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  24'hFF_FFFF, 24'hFF_FFFF, sts);
        send_item(rrp_pkg::OP_APPEND, 32'd5, 32'd4, 32'd0, 24'd0, 24'd0, sts);
        send_item(rrp_pkg::OP_APPEND, 32'd0, 32'd0, 32'd0, 24'd0, 24'd0, sts);
        send_item(rrp_pkg::OP_APPEND, 32'd0, 32'hFFFF_FFFF, 32'd0, 24'd0, 24'd0, sts);
        send_item(rrp_pkg::OP_APPEND, 32'd100, 32'd199, 32'd0, 24'd0, 24'd0, sts);
        send_item(rrp_pkg::OP_PLACE, 32'd0, 32'd0, 32'd1, 24'd0, 24'd0, sts);
        send_item(rrp_pkg::OP_PLACE, 32'd0, 32'd0, 32'd1, 24'hFF_FFFF, 24'hFF_FFFF, sts);
        send_item(rrp_pkg::OP_PLACE, 32'd0, 32'd0, 32'hFFFF_FFFF, 24'h80_0000,
                  24'hFF_FFFF, sts);
        // zero length: placed_last wraps below placed_first
        send_item(rrp_pkg::OP_PLACE, 32'd0, 32'd0, 32'd0, 24'h7F_FFFF, 24'hFF_FFFF, sts);
        // interval too short
        send_item(rrp_pkg::OP_PLACE, 32'd0, 32'd0, 32'd2, 24'd0, 24'h12_3456, sts);
        // top select with length 100 picks the full-range entry
        send_item(rrp_pkg::OP_PLACE, 32'd0, 32'd0, 32'd100, 24'hFF_FFFF, 24'hFF_FFFF, sts);
        send_item(rrp_pkg::OP_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 24'd0, 24'd0,
                  sts);
        send_item(rrp_pkg::OP_PLACE, 32'd0, 32'd0, 32'd1, 24'hFF_FFFF, 24'hFF_FFFF, sts);
        send_item(rrp_pkg::OP_CLEAR, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 24'hFF_FFFF,
                  24'd0, sts);
        send_item(rrp_pkg::OP_PLACE, 32'd0, 32'd0, 32'd1, 24'd0, 24'd0, sts);
        send_item(rrp_pkg::OP_APPEND, 32'hFFFF_FFFF, 32'd0, 32'd0, 24'd0, 24'd0, sts);
        send_item(rrp_pkg::OP_APPEND, 32'd7, 32'd7, 32'd0, 24'd0, 24'd0, sts);
        send_item(rrp_pkg::OP_PLACE, 32'd0, 32'd0, 32'd0, 24'h55_5555, 24'hFF_FFFF, sts);
        send_item(rrp_pkg::OP_PLACE, 32'd0, 32'd0, 32'd1, 24'hAA_AAAA, 24'hFF_FFFF, sts);
    endtask

    task automatic test_fill_table();
        rrp_pkg::status_t sts;
        int i;
        send_item(rrp_pkg::OP_CLEAR, rand_word(), rand_word(), rand_word(), rand_frac(),
                  rand_frac(), sts);
        for (i = 0; i < TABLE_DEPTH; i++) begin
            if (i % 4 == 0)
                send_item(rrp_pkg::OP_APPEND, 32'd0, 32'hFFFF_FFFF, rand_word(),
                          rand_frac(), rand_frac(), sts);
            else
                append_random(1'b0);
        end
        // full table wins over a bad interval
        send_item(rrp_pkg::OP_APPEND, 32'd0, 32'hFFFF_FFFF, 32'd0, 24'd0, 24'd0, sts);
        send_item(rrp_pkg::OP_APPEND, 32'd9, 32'd3, 32'd0, 24'd0, 24'd0, sts);
        send_item(rrp_pkg::OP_PLACE, 32'd0, 32'd0, 32'd1, 24'hFF_FFFF, 24'hFF_FFFF, sts);
        send_item(rrp_pkg::OP_PLACE, 32'd0, 32'd0, 32'd1, 24'd0, 24'd0, sts);
        repeat (6) place_with_retry();
    endtask

    task automatic test_random_sequences();
        int i, n;
        rrp_pkg::status_t sts;
        while (items_sent < RANDOM_TARGET) begin
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 2))
                    0: send_item(OP_RESERVED, rand_word(), rand_word(), rand_word(),
                                 rand_frac(), rand_frac(), sts);
                    1: append_random(1'b1);
                    default: send_item(rrp_pkg::OP_PLACE, rand_word(), rand_word(),
                                       rand_word(), rand_frac(), rand_frac(), sts);
                endcase
            end else begin
                if ($urandom_range(0, 9) < 7)
                    send_item(rrp_pkg::OP_CLEAR, rand_word(), rand_word(), rand_word(),
                              rand_frac(), rand_frac(), sts);
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                for (i = 0; i < n; i++)
                    append_random($urandom_range(0, 15) == 0);
                n = $urandom_range(2, 10);
                for (i = 0; i < n; i++)
                    place_with_retry();
            end
        end
    endtask

    task automatic test_output_hold();
        rrp_pkg::status_t sts;
        send_item(rrp_pkg::OP_CLEAR, rand_word(), rand_word(), rand_word(), rand_frac(),
                  rand_frac(), sts);
        repeat (3) append_random(1'b0);
        rx_hold_cycles = 300;
        repeat (12) place_with_retry();
    endtask

    task automatic test_sender_pause();
        repeat (4) place_with_retry();
        wait_drained();
        repeat (4) place_with_retry();
        wait_drained();
        append_random(1'b0);
        place_with_retry();
    endtask

    task automatic test_back_to_back();
        int i;
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        for (i = 0; i < 30; i++) begin
            if (i % 5 == 0)
                append_random(1'b0);
            else
                place_with_retry();
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_cases();
        test_fill_table();
        test_output_hold();
        test_sender_pause();
        test_random_sequences();
        test_back_to_back();
        wait_drained();
        repeat (32) @(posedge aclk);
        if (error_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
